FILE: hw/rtl/itpt_pkg.sv
// shared types, character codes and digit lookup for the integer text formatter
package itpt_pkg;

  localparam int VALUE_BITS_DEF = 64;
  localparam int MAX_FIELD_DEF  = 64;

  localparam logic [1:0] RSEL_OCT = 2'd0;
  localparam logic [1:0] RSEL_DEC = 2'd1;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_A_UP  = 8'h41;
  localparam logic [7:0] CH_X_UP  = 8'h58;
  localparam logic [7:0] CH_A_LO  = 8'h61;
  localparam logic [7:0] CH_X_LO  = 8'h78;

  typedef enum logic [1:0] {
    BASE_OCT,
    BASE_DEC,
    BASE_HEX
  } base_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_CLEAR,
    CELL_BIT,
    CELL_DIGIT
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    base_t    base;
  } cell_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_NORM,
    ST_SETUP,
    ST_SPAN,
    ST_PLACE,
    ST_EMIT
  } state_t;

  function automatic logic [7:0] digit_char(logic [3:0] d, logic upper);
    logic [7:0] ch;
    if (d < 4'd10) begin
      ch = CH_ZERO + {4'd0, d};
    end else begin
      ch = (upper ? CH_A_UP : CH_A_LO) + {4'd0, d - 4'd10};
    end
    return ch;
  endfunction

endpackage

FILE: hw/rtl/integer_to_padded_text.sv
// top level: printf style integer to text, one character per output beat
// An item is taken only while the block is idle. The value then shifts, most
// significant bit first, into a row of (VALUE_BITS+2)/3 digit cells, one bit
// per cycle, doing octal, decimal (shift and add three) or hex conversion in
// the same cells. Leading zero digits are then shifted out, one per cycle,
// keeping at least one digit, followed by the layout steps SETUP, SPAN and
// PLACE. Characters then leave at one per cycle while out_stall is low, at
// most MAX_FIELD of them. The next item is taken in the cycle after the
// last character enters the output register. Empty text gives no beat.
module integer_to_padded_text import itpt_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int MAX_FIELD  = MAX_FIELD_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [63:0]       in_magnitude,
  input  logic              in_is_negative,
  input  logic [1:0]        in_radix_select,
  input  logic              in_uppercase,
  input  logic              in_alternate_form,
  input  logic              in_left_align,
  input  logic              in_force_plus,
  input  logic              in_space_sign,
  input  logic              in_zero_pad,
  input  logic [6:0]        in_field_width,
  input  logic signed [6:0] in_min_digits,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_character,
  output logic              out_last
);

  localparam int NCELL = (VALUE_BITS + 2) / 3;
  localparam int NW    = $clog2(NCELL + 1);
  localparam int BW    = $clog2(VALUE_BITS);
  localparam int LW    = $clog2(2 * MAX_FIELD + NCELL + 4);

  state_t            state_r, state_nxt;
  logic [VALUE_BITS-1:0] val_r, val_nxt;
  logic              zero_r, zero_nxt;
  logic              neg_r, neg_nxt;
  logic              plus_r, plus_nxt;
  logic              space_r, space_nxt;
  logic              upper_r, upper_nxt;
  logic              alt_r, alt_nxt;
  logic              left_r, left_nxt;
  logic              zpad_r, zpad_nxt;
  base_t             base_r, base_nxt;
  logic [LW-1:0]     width_r, width_nxt;
  logic              has_prec_r, has_prec_nxt;
  logic [LW-1:0]     prec_r, prec_nxt;
  logic [BW-1:0]     bitcnt_r, bitcnt_nxt;
  logic [NW-1:0]     ndig_r, ndig_nxt;
  logic [LW-1:0]     ndeff_r, ndeff_nxt;
  logic [LW-1:0]     pz_r, pz_nxt;
  logic [1:0]        npre_r, npre_nxt;
  logic [7:0]        pre0_r, pre0_nxt;
  logic [7:0]        pre1_r, pre1_nxt;
  logic [7:0]        pre2_r, pre2_nxt;
  logic [LW-1:0]     span_r, span_nxt;
  logic [LW-1:0]     total_r, total_nxt;
  logic [LW-1:0]     a_r, a_nxt;
  logic [LW-1:0]     b_r, b_nxt;
  logic [LW-1:0]     c_r, c_nxt;
  logic [LW-1:0]     d_r, d_nxt;
  logic [LW-1:0]     len_r, len_nxt;
  logic [LW-1:0]     pos_r, pos_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_char_r, out_char_nxt;
  logic              out_last_r, out_last_nxt;

  cell_ctl_t         ctl;
  logic              chain_bit;
  logic [3:0]        top_digit;
  logic              top_carry;
  logic              in_accept;
  logic              out_load;

  logic [6:0]        w_sat;
  logic [5:0]        p_sat;
  logic [LW-1:0]     ndeff;
  logic [LW-1:0]     pz;
  logic              sgn;
  logic [7:0]        sgn_ch;
  logic [7:0]        x_ch;
  logic              hexp;
  logic              octp;
  logic [LW-1:0]     zsum;
  logic [LW-1:0]     zeros;
  logic [LW-1:0]     padn;
  logic [LW-1:0]     a_pos;
  logic [LW-1:0]     ext;
  logic [LW-1:0]     pre_off;
  logic              last_beat;

  itpt_chain #(
    .VALUE_BITS (VALUE_BITS)
  ) u_chain (
    .clk       (clk),
    .ctl       (ctl),
    .bit_in    (chain_bit),
    .top_digit (top_digit),
    .top_carry (top_carry)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign chain_bit = val_r[VALUE_BITS-1];

  always_comb begin
    state_nxt     = state_r;
    val_nxt       = val_r;
    zero_nxt      = zero_r;
    neg_nxt       = neg_r;
    plus_nxt      = plus_r;
    space_nxt     = space_r;
    upper_nxt     = upper_r;
    alt_nxt       = alt_r;
    left_nxt      = left_r;
    zpad_nxt      = zpad_r;
    base_nxt      = base_r;
    width_nxt     = width_r;
    has_prec_nxt  = has_prec_r;
    prec_nxt      = prec_r;
    bitcnt_nxt    = bitcnt_r;
    ndig_nxt      = ndig_r;
    ndeff_nxt     = ndeff_r;
    pz_nxt        = pz_r;
    npre_nxt      = npre_r;
    pre0_nxt      = pre0_r;
    pre1_nxt      = pre1_r;
    pre2_nxt      = pre2_r;
    span_nxt      = span_r;
    total_nxt     = total_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    c_nxt         = c_r;
    d_nxt         = d_r;
    len_nxt       = len_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_load      = 1'b0;
    ctl.op        = CELL_HOLD;
    ctl.base      = base_r;

    w_sat   = (in_field_width > 7'(MAX_FIELD)) ? 7'(MAX_FIELD) : in_field_width;
    p_sat   = (in_min_digits[5:0] > 6'(MAX_FIELD - 4)) ? 6'(MAX_FIELD - 4)
                                                        : in_min_digits[5:0];
    ndeff   = (has_prec_r && prec_r == '0 && zero_r) ? '0 : LW'(ndig_r);
    pz      = (has_prec_r && prec_r > ndeff) ? prec_r - ndeff : '0;
    sgn     = neg_r || plus_r || space_r;
    sgn_ch  = neg_r ? CH_MINUS : (plus_r ? CH_PLUS : CH_SPACE);
    x_ch    = upper_r ? CH_X_UP : CH_X_LO;
    hexp    = alt_r && base_r == BASE_HEX && !zero_r;
    octp    = alt_r && base_r == BASE_OCT && pz == '0 && (ndeff == '0 || !zero_r);
    zsum    = LW'(npre_r) + ndeff_r;
    zeros   = (zpad_r && !left_r && !has_prec_r && width_r > zsum) ? width_r - zsum : pz_r;
    padn    = (width_r > total_r) ? width_r - total_r : '0;
    a_pos   = left_r ? '0 : padn;
    ext     = (width_r > total_r) ? width_r : total_r;
    pre_off = pos_r - a_r;
    last_beat = (pos_r + LW'(1)) == len_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          val_nxt      = in_magnitude[VALUE_BITS-1:0];
          zero_nxt     = (in_magnitude[VALUE_BITS-1:0] == '0);
          neg_nxt      = in_is_negative;
          plus_nxt     = in_force_plus;
          space_nxt    = in_space_sign;
          upper_nxt    = in_uppercase;
          alt_nxt      = in_alternate_form;
          left_nxt     = in_left_align;
          zpad_nxt     = in_zero_pad;
          base_nxt     = (in_radix_select == RSEL_OCT) ? BASE_OCT :
                         (in_radix_select == RSEL_DEC) ? BASE_DEC : BASE_HEX;
          width_nxt    = LW'(w_sat);
          has_prec_nxt = !in_min_digits[6];
          prec_nxt     = in_min_digits[6] ? '0 : LW'(p_sat);
          bitcnt_nxt   = '0;
          ctl.op       = CELL_CLEAR;
          state_nxt    = ST_CONV;
        end
      end
      ST_CONV: begin
        ctl.op     = CELL_BIT;
        val_nxt    = {val_r[VALUE_BITS-2:0], 1'b0};
        bitcnt_nxt = bitcnt_r + BW'(1);
        if (bitcnt_r == BW'(VALUE_BITS - 1)) begin
          ndig_nxt  = NW'(NCELL);
          state_nxt = ST_NORM;
        end
      end
      ST_NORM: begin
        // drop leading zero digits, keep at least one
        if (ndig_r > NW'(1) && top_digit == 4'd0) begin
          ctl.op   = CELL_DIGIT;
          ndig_nxt = ndig_r - NW'(1);
        end else begin
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        ndeff_nxt = ndeff;
        pz_nxt    = pz;
        npre_nxt  = {1'b0, sgn} + {hexp, 1'b0} + {1'b0, octp};
        pre0_nxt  = sgn ? sgn_ch : CH_ZERO;
        pre1_nxt  = sgn ? CH_ZERO : x_ch;
        pre2_nxt  = x_ch;
        state_nxt = ST_SPAN;
      end
      ST_SPAN: begin
        span_nxt  = LW'(npre_r) + zeros;
        total_nxt = zsum + zeros;
        state_nxt = ST_PLACE;
      end
      ST_PLACE: begin
        a_nxt     = a_pos;
        b_nxt     = a_pos + LW'(npre_r);
        c_nxt     = a_pos + span_r;
        d_nxt     = a_pos + total_r;
        len_nxt   = (ext > LW'(MAX_FIELD)) ? LW'(MAX_FIELD) : ext;
        pos_nxt   = '0;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (len_r == '0) begin
          state_nxt = ST_IDLE;
        end else if (!out_valid_r || !out_stall) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          out_last_nxt  = last_beat;
          pos_nxt       = pos_r + LW'(1);
          priority if (pos_r < a_r) begin
            out_char_nxt = CH_SPACE;
          end else if (pos_r < b_r) begin
            unique case (pre_off[1:0])
              2'd0:    out_char_nxt = pre0_r;
              2'd1:    out_char_nxt = pre1_r;
              default: out_char_nxt = pre2_r;
            endcase
          end else if (pos_r < c_r) begin
            out_char_nxt = CH_ZERO;
          end else if (pos_r < d_r) begin
            out_char_nxt = digit_char(top_digit, upper_r);
            ctl.op       = CELL_DIGIT;
          end else begin
            out_char_nxt = CH_SPACE;
          end
          if (last_beat) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r      <= val_nxt;
    zero_r     <= zero_nxt;
    neg_r      <= neg_nxt;
    plus_r     <= plus_nxt;
    space_r    <= space_nxt;
    upper_r    <= upper_nxt;
    alt_r      <= alt_nxt;
    left_r     <= left_nxt;
    zpad_r     <= zpad_nxt;
    base_r     <= base_nxt;
    width_r    <= width_nxt;
    has_prec_r <= has_prec_nxt;
    prec_r     <= prec_nxt;
    bitcnt_r   <= bitcnt_nxt;
    ndig_r     <= ndig_nxt;
    ndeff_r    <= ndeff_nxt;
    pz_r       <= pz_nxt;
    npre_r     <= npre_nxt;
    pre0_r     <= pre0_nxt;
    pre1_r     <= pre1_nxt;
    pre2_r     <= pre2_nxt;
    span_r     <= span_nxt;
    total_r    <= total_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    c_r        <= c_nxt;
    d_r        <= d_nxt;
    len_r      <= len_nxt;
    pos_r      <= pos_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;

`ifndef NO_ASSERTIONS
  // the digit row is wide enough that no bit falls off the top
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CONV |-> !top_carry)
    else $error("digit row overflow during conversion");

  a_dec_digit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && base_r == BASE_DEC) |-> top_digit < 4'd10)
    else $error("decimal cell holds a non-decimal digit");

  a_ndig_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_NORM |-> ndig_r != '0)
    else $error("digit count reached zero while trimming");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && out_last_nxt) |=> (state_r == ST_IDLE && out_valid_r && out_last_r))
    else $error("final beat did not end the conversion");
`endif

endmodule

FILE: hw/rtl/itpt_cell.sv
// one digit cell: holds, clears, shifts in a bit per radix rule or takes its neighbor's digit
module itpt_cell import itpt_pkg::*; (
  input  logic       clk,
  input  cell_ctl_t  ctl,
  input  logic       bit_in,
  input  logic [3:0] digit_in,
  output logic       bit_out,
  output logic [3:0] digit
);

  logic [3:0] digit_r;
  logic [3:0] digit_nxt;
  logic [3:0] adj;
  logic [3:0] shifted;

  always_comb begin
    adj = digit_r;
    unique case (ctl.base)
      BASE_OCT: begin
        bit_out = digit_r[2];
        shifted = {1'b0, digit_r[1:0], bit_in};
      end
      BASE_DEC: begin
        // add three before the shift keeps the digit decimal
        if (digit_r >= 4'd5) begin
          adj = digit_r + 4'd3;
        end
        bit_out = adj[3];
        shifted = {adj[2:0], bit_in};
      end
      default: begin
        bit_out = digit_r[3];
        shifted = {digit_r[2:0], bit_in};
      end
    endcase

    unique case (ctl.op)
      CELL_HOLD:  digit_nxt = digit_r;
      CELL_CLEAR: digit_nxt = 4'd0;
      CELL_BIT:   digit_nxt = shifted;
      CELL_DIGIT: digit_nxt = digit_in;
      default:    digit_nxt = digit_r;
    endcase
  end

  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
  end

  assign digit = digit_r;

endmodule

FILE: hw/rtl/itpt_chain.sv
// row of digit cells, least significant at the bottom, most significant at the top
module itpt_chain import itpt_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic       clk,
  input  cell_ctl_t  ctl,
  input  logic       bit_in,
  output logic [3:0] top_digit,
  output logic       top_carry
);

  localparam int NCELL = (VALUE_BITS + 2) / 3;

  logic [NCELL:0] carry;
  logic [3:0]     dlink [NCELL+1];

  assign carry[0] = bit_in;
  assign dlink[0] = 4'd0;

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    itpt_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .bit_in   (carry[i]),
      .digit_in (dlink[i]),
      .bit_out  (carry[i+1]),
      .digit    (dlink[i+1])
    );
  end

  assign top_digit = dlink[NCELL];
  assign top_carry = carry[NCELL];

endmodule

FILE: tb/integer_to_padded_text_test.sv
// self-checking testbench for integer_to_padded_text: queued driver, stall-driven receiver, text predictor
module integer_to_padded_text_test import itpt_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] RSEL_HEX = 2'd2;
  localparam logic [1:0] RSEL_HEX_ALIAS = 2'd3;
  localparam logic signed [6:0] NO_PREC = -7'sd1;
  localparam int unsigned FIELD_CAP = 64;
  localparam int unsigned PREC_CAP = FIELD_CAP - 4;
  localparam int unsigned RANDOM_REQS = 500;
  localparam int unsigned MAX_IDLE = 14;

  typedef struct {
    logic [63:0]       magnitude;
    logic              is_negative;
    logic [1:0]        radix_select;
    logic              uppercase;
    logic              alternate_form;
    logic              left_align;
    logic              force_plus;
    logic              space_sign;
    logic              zero_pad;
    logic [6:0]        field_width;
    logic signed [6:0] min_digits;
    bit                drain_first;
  } conv_req_t;

  typedef struct {
    logic [7:0] character;
    logic       last;
  } text_beat_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [63:0]       in_magnitude = '0;
  logic              in_is_negative = 1'b0;
  logic [1:0]        in_radix_select = '0;
  logic              in_uppercase = 1'b0;
  logic              in_alternate_form = 1'b0;
  logic              in_left_align = 1'b0;
  logic              in_force_plus = 1'b0;
  logic              in_space_sign = 1'b0;
  logic              in_zero_pad = 1'b0;
  logic [6:0]        in_field_width = '0;
  logic signed [6:0] in_min_digits = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [7:0]        out_character;
  logic              out_last;

  conv_req_t   req_queue[$];
  text_beat_t  text_queue[$];
  int unsigned mismatches = 0;
  int unsigned accepted_reqs = 0;
  int unsigned total_reqs = 0;
  logic        in_fire = 1'b0;
  logic        out_fire = 1'b0;
  int unsigned send_wait = 0;
  int unsigned recv_wait = 0;
  bit          send_quiet = 1'b0;
  bit          recv_quiet = 1'b0;

  integer_to_padded_text dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_magnitude      (in_magnitude),
    .in_is_negative    (in_is_negative),
    .in_radix_select   (in_radix_select),
    .in_uppercase      (in_uppercase),
    .in_alternate_form (in_alternate_form),
    .in_left_align     (in_left_align),
    .in_force_plus     (in_force_plus),
    .in_space_sign     (in_space_sign),
    .in_zero_pad       (in_zero_pad),
    .in_field_width    (in_field_width),
    .in_min_digits     (in_min_digits),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_character     (out_character),
    .out_last          (out_last)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // expected characters of one conversion
  function automatic void format_integer(conv_req_t r);
    logic [7:0]  digits_rev[64];
    logic [7:0]  head[3];
    logic [7:0]  text[$];
    logic [63:0] v;
    logic [63:0] radix;
    logic [3:0]  d;
    base_t       base;
    logic        has_prec;
    int unsigned width, prec, ndig, npre, zeros, total, k;
    text_beat_t  beat;
    width = (r.field_width > FIELD_CAP) ? FIELD_CAP : r.field_width;
    has_prec = !r.min_digits[6];
    prec = has_prec ? int'(unsigned'(r.min_digits)) : 0;
    if (prec > PREC_CAP) prec = PREC_CAP;
    case (r.radix_select)
      RSEL_OCT: base = BASE_OCT;
      RSEL_DEC: base = BASE_DEC;
      default:  base = BASE_HEX;
    endcase
    radix = (base == BASE_OCT) ? 64'd8 : ((base == BASE_DEC) ? 64'd10 : 64'd16);
    v = r.magnitude;
    ndig = 0;
    npre = 0;
    zeros = 0;
    do begin
      d = 4'(v % radix);
      digits_rev[ndig] = (d < 4'd10) ? CH_ZERO + 8'(d)
                                     : (r.uppercase ? CH_A_UP : CH_A_LO) + 8'(d - 4'd10);
      ndig++;
      v = v / radix;
    end while (v != 0 && ndig < 64);
    if (has_prec && prec == 0 && r.magnitude == 0) ndig = 0;
    if (r.is_negative) begin
      head[npre] = CH_MINUS;
      npre = npre + 1;
    end else if (r.force_plus) begin
      head[npre] = CH_PLUS;
      npre = npre + 1;
    end else if (r.space_sign) begin
      head[npre] = CH_SPACE;
      npre = npre + 1;
    end
    if (has_prec && prec > ndig) zeros = prec - ndig;
    if (r.alternate_form && base == BASE_HEX && r.magnitude != 0) begin
      head[npre] = CH_ZERO;
      head[npre + 1] = r.uppercase ? CH_X_UP : CH_X_LO;
      npre = npre + 2;
    end else if (r.alternate_form && base == BASE_OCT && zeros == 0 &&
                 (ndig == 0 || r.magnitude != 0)) begin
      head[npre] = CH_ZERO;
      npre = npre + 1;
    end
    if (r.zero_pad && !r.left_align && !has_prec && width > npre + ndig)
      zeros = width - npre - ndig;
    total = npre + zeros + ndig;
    if (!r.left_align && width > total)
      for (k = 0; k < width - total; k++) text.push_back(CH_SPACE);
    for (k = 0; k < npre; k++) text.push_back(head[k]);
    for (k = 0; k < zeros; k++) text.push_back(CH_ZERO);
    for (k = ndig; k != 0; k--) text.push_back(digits_rev[k - 1]);
    if (r.left_align && width > total)
      for (k = 0; k < width - total; k++) text.push_back(CH_SPACE);
    while (text.size() > FIELD_CAP) void'(text.pop_back());
    for (k = 0; k < text.size(); k++) begin
      beat.character = text[k];
      beat.last = (k + 1 == text.size());
      text_queue.push_back(beat);
    end
  endfunction

  function automatic conv_req_t plain(logic [63:0] mag, logic [1:0] rsel);
    conv_req_t r;
    r = '{default: '0};
    r.magnitude = mag;
    r.radix_select = rsel;
    r.min_digits = NO_PREC;
    return r;
  endfunction

  function automatic void queue_req(conv_req_t r);
    req_queue.push_back(r);
    total_reqs++;
  endfunction

  // input driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_wait = $urandom_range(0, MAX_IDLE);
    end else if (!in_valid || in_fire) begin
      if (send_wait != 0) begin
        send_wait--;
        in_valid <= 1'b0;
      end else if (req_queue.size() != 0 &&
                   !(req_queue[0].drain_first && text_queue.size() != 0)) begin
        conv_req_t r;
        r = req_queue.pop_front();
        in_magnitude <= r.magnitude;
        in_is_negative <= r.is_negative;
        in_radix_select <= r.radix_select;
        in_uppercase <= r.uppercase;
        in_alternate_form <= r.alternate_form;
        in_left_align <= r.left_align;
        in_force_plus <= r.force_plus;
        in_space_sign <= r.space_sign;
        in_zero_pad <= r.zero_pad;
        in_field_width <= r.field_width;
        in_min_digits <= r.min_digits;
        in_valid <= 1'b1;
        if ($urandom_range(0, 39) == 0) send_quiet = !send_quiet;
        send_wait = send_quiet ? 0 : $urandom_range(0, MAX_IDLE);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output backpressure
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      recv_wait = 0;
    end else begin
      if (out_fire) begin
        if ($urandom_range(0, 39) == 0) recv_quiet = !recv_quiet;
        recv_wait = recv_quiet ? 0 : $urandom_range(0, MAX_IDLE);
      end
      if (recv_wait != 0) begin
        recv_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // monitor: check output beats, predict on accepted input beats
  always @(posedge clk) begin
    in_fire <= rst_n && in_valid && !in_stall;
    out_fire <= rst_n && out_valid && !out_stall;
    if (rst_n && out_valid && !out_stall) begin
      if (text_queue.size() == 0) begin
        $error("unexpected beat: character %h last %b", out_character, out_last);
        mismatches++;
      end else begin
        text_beat_t want;
        want = text_queue.pop_front();
        if (out_character !== want.character) begin
          $error("character: expected %h got %h", want.character, out_character);
          mismatches++;
        end
        if (out_last !== want.last) begin
          $error("last: expected %b got %b", want.last, out_last);
          mismatches++;
        end
      end
    end
    if (rst_n && in_valid && !in_stall) begin
      conv_req_t r;
      r.magnitude = in_magnitude;
      r.is_negative = in_is_negative;
      r.radix_select = in_radix_select;
      r.uppercase = in_uppercase;
      r.alternate_form = in_alternate_form;
      r.left_align = in_left_align;
      r.force_plus = in_force_plus;
      r.space_sign = in_space_sign;
      r.zero_pad = in_zero_pad;
      r.field_width = in_field_width;
      r.min_digits = in_min_digits;
      r.drain_first = 1'b0;
      format_integer(r);
      accepted_reqs++;
    end
  end

  initial begin
    conv_req_t r;
    int unsigned i;
    int unsigned shape;
    // directed
    r = plain(64'd0, RSEL_DEC); queue_req(r);
    r = plain(64'd0, RSEL_DEC); r.min_digits = 7'sd0; queue_req(r);
    r = plain(64'd0, RSEL_DEC); r.min_digits = 7'sd0; r.field_width = 7'd5; queue_req(r);
    r = plain('1, RSEL_OCT); r.alternate_form = 1'b1; queue_req(r);
    r = plain('1, RSEL_HEX); r.alternate_form = 1'b1; r.uppercase = 1'b1; queue_req(r);
    r = plain('1, RSEL_DEC); r.is_negative = 1'b1; r.zero_pad = 1'b1;
    r.field_width = 7'd64; queue_req(r);
    r = plain(64'd0, RSEL_HEX); r.alternate_form = 1'b1; queue_req(r);
    r = plain(64'd0, RSEL_OCT); r.alternate_form = 1'b1; r.min_digits = 7'sd0; queue_req(r);
    r = plain(64'd7, RSEL_OCT); r.alternate_form = 1'b1; r.min_digits = 7'sd5; queue_req(r);
    r = plain(64'd42, RSEL_DEC); r.force_plus = 1'b1; r.space_sign = 1'b1; queue_req(r);
    r = plain(64'd42, RSEL_DEC); r.space_sign = 1'b1; queue_req(r);
    r = plain(64'd42, RSEL_DEC); r.is_negative = 1'b1; r.force_plus = 1'b1;
    r.space_sign = 1'b1; queue_req(r);
    r = plain(64'd1234, RSEL_DEC); r.left_align = 1'b1; r.field_width = 7'd20; queue_req(r);
    r = plain(64'd99, RSEL_DEC); r.zero_pad = 1'b1; r.min_digits = 7'sd4;
    r.field_width = 7'd10; queue_req(r);
    r = plain(64'd99, RSEL_DEC); r.zero_pad = 1'b1; r.left_align = 1'b1;
    r.field_width = 7'd10; r.drain_first = 1'b1; queue_req(r);
    r = plain(64'd5, RSEL_DEC); r.field_width = 7'd127; queue_req(r);
    r = plain(64'd5, RSEL_DEC); r.min_digits = 7'sd60; queue_req(r);
    r = plain(64'd5, RSEL_DEC); r.min_digits = 7'sd63; queue_req(r);
    r = plain(64'd5, RSEL_DEC); r.min_digits = -7'sd64; r.zero_pad = 1'b1;
    r.field_width = 7'd8; queue_req(r);
    r = plain(64'hdead_beef_0123_4567, RSEL_HEX_ALIAS); r.alternate_form = 1'b1; queue_req(r);
    r = plain(64'hcafe_f00d, RSEL_HEX); r.alternate_form = 1'b1; r.uppercase = 1'b0;
    queue_req(r);
    r = plain(64'hfedc_ba98_7654_3210, RSEL_HEX); r.is_negative = 1'b1;
    r.alternate_form = 1'b1; r.uppercase = 1'b1; r.min_digits = 7'sd60;
    r.field_width = 7'd64; queue_req(r);
    r = plain('1, RSEL_DEC); r.force_plus = 1'b1; r.min_digits = 7'sd60;
    r.left_align = 1'b1; r.field_width = 7'd100; queue_req(r);
    // random
    for (i = 0; i < RANDOM_REQS; i++) begin
      r = plain({$urandom, $urandom}, 2'($urandom_range(0, 3)));
      shape = $urandom_range(0, 3);
      if (shape == 1) r.magnitude = 64'($urandom_range(0, 1000));
      else if (shape == 2) r.magnitude = r.magnitude >> $urandom_range(0, 63);
      r.is_negative = 1'($urandom_range(0, 1));
      r.uppercase = 1'($urandom_range(0, 1));
      r.alternate_form = 1'($urandom_range(0, 1));
      r.left_align = 1'($urandom_range(0, 1));
      r.force_plus = 1'($urandom_range(0, 1));
      r.space_sign = 1'($urandom_range(0, 1));
      r.zero_pad = 1'($urandom_range(0, 1));
      r.field_width = ($urandom_range(0, 4) == 0) ? 7'($urandom) : 7'($urandom_range(0, 30));
      case ($urandom_range(0, 3))
        0: r.min_digits = NO_PREC;
        1: r.min_digits = 7'($urandom);
        default: r.min_digits = 7'($urandom_range(0, 25));
      endcase
      r.drain_first = ($urandom_range(0, 99) == 0);
      queue_req(r);
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    wait (accepted_reqs == total_reqs);
    while (text_queue.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
